// File: design/ordered_list_store_top_defines.svh
// Assertion macros of the list store RTL, used by the sequencer.
`ifndef ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_TOP_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define OLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define OLS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/ols_pkg.sv
// Types and constants of the ordered list store.
`default_nettype none

package ols_pkg;

    localparam int OLS_CAPACITY = 16;
    localparam int OLS_DATA_W   = 32;
    localparam int OLS_LEN_W    = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_DUMP   = 2'd3
    } t_ols_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_ols_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WALK,
        S_TAIL
    } t_ols_state;

    typedef struct packed {
        t_ols_action                  action;
        logic signed [OLS_DATA_W-1:0] value;
    } t_ols_in;

    typedef struct packed {
        t_ols_status                  status;
        logic signed [OLS_DATA_W-1:0] item;
        logic                         last;
        logic [OLS_LEN_W-1:0]         length;
    } t_ols_out;

endpackage

`default_nettype wire

// File: design/ordered_list_store_top.sv
// Ordered list store: top level joining the sequencer and the slot memories.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one request: an
//   action (insert at front, append at back, delete first match, dump) and a
//   signed 32-bit value. Output channel (o_out_valid / i_out_ready / o_out)
//   carries results: status, item, last and length after the request.
//   Every request gives one result, except a dump of a non-empty list, which
//   gives one result per element, front to back, last marked.
//   o_in_ready is high only while the sequencer is idle; a request is taken
//   even while the previous result still waits in the output register.
//   The start state reads the head; front insert, rejects and empty-list
//   cases give their result there. Append walks to the tail, links the new
//   slot behind it and writes it in the tail state; delete walks to a match
//   or the tail; a dump gives each element as it walks. One link per cycle
//   is followed through the registered read port, unless a stalled receiver
//   holds the sequencer at a result; nothing is lost or repeated. No new
//   request is taken before the final result is registered.
//   Synchronous active-low reset empties the list and drops any pending
//   result; memory contents are not cleared and need not be.
`default_nettype none

module ordered_list_store_top #(
    parameter int CAPACITY = ols_pkg::OLS_CAPACITY
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ols_pkg::t_ols_in  i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ols_pkg::t_ols_out      o_out
);

    localparam int SW = $clog2(CAPACITY);

    logic [SW-1:0]                         rd_addr;
    logic signed [ols_pkg::OLS_DATA_W-1:0] rd_elem;
    logic [SW-1:0]                         rd_link;
    logic                                  elem_we;
    logic [SW-1:0]                         elem_waddr;
    logic signed [ols_pkg::OLS_DATA_W-1:0] elem_wdata;
    logic                                  link_we;
    logic [SW-1:0]                         link_waddr;
    logic [SW-1:0]                         link_wdata;

    ols_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out),
        .o_rd_addr    (rd_addr),
        .i_rd_elem    (rd_elem),
        .i_rd_link    (rd_link),
        .o_elem_we    (elem_we),
        .o_elem_waddr (elem_waddr),
        .o_elem_wdata (elem_wdata),
        .o_link_we    (link_we),
        .o_link_waddr (link_waddr),
        .o_link_wdata (link_wdata)
    );

    ols_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_addr    (rd_addr),
        .o_rd_elem    (rd_elem),
        .o_rd_link    (rd_link),
        .i_elem_we    (elem_we),
        .i_elem_waddr (elem_waddr),
        .i_elem_wdata (elem_wdata),
        .i_link_we    (link_we),
        .i_link_waddr (link_waddr),
        .i_link_wdata (link_wdata)
    );

endmodule

`default_nettype wire

// File: design/ols_store.sv
// Element and link memories: one write port each, one shared registered read port.
`default_nettype none

module ols_store #(
    parameter int CAPACITY = ols_pkg::OLS_CAPACITY,
    localparam int SW = $clog2(CAPACITY)
) (
    input  wire logic                                  i_clk,
    input  wire logic [SW-1:0]                         i_rd_addr,
    output logic signed [ols_pkg::OLS_DATA_W-1:0]      o_rd_elem,
    output logic [SW-1:0]                              o_rd_link,
    input  wire logic                                  i_elem_we,
    input  wire logic [SW-1:0]                         i_elem_waddr,
    input  wire logic signed [ols_pkg::OLS_DATA_W-1:0] i_elem_wdata,
    input  wire logic                                  i_link_we,
    input  wire logic [SW-1:0]                         i_link_waddr,
    input  wire logic [SW-1:0]                         i_link_wdata
);

    logic signed [ols_pkg::OLS_DATA_W-1:0] elem_mem [CAPACITY];
    logic [SW-1:0]                         link_mem [CAPACITY];
    logic signed [ols_pkg::OLS_DATA_W-1:0] r_rd_elem;
    logic [SW-1:0]                         r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_elem_we) begin
            elem_mem[i_elem_waddr] <= i_elem_wdata;
        end
        r_rd_elem <= elem_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            link_mem[i_link_waddr] <= i_link_wdata;
        end
        r_rd_link <= link_mem[i_rd_addr];
    end

    assign o_rd_elem = r_rd_elem;
    assign o_rd_link = r_rd_link;

endmodule

`default_nettype wire

// File: design/ols_ctrl.sv
// Request sequencer: list walk, free map, head and count, result register.
`default_nettype none
`include "ordered_list_store_top_defines.svh"

module ols_ctrl #(
    parameter int CAPACITY = ols_pkg::OLS_CAPACITY,
    localparam int SW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire ols_pkg::t_ols_in                      i_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output ols_pkg::t_ols_out                          o_out,
    output logic [SW-1:0]                              o_rd_addr,
    input  wire logic signed [ols_pkg::OLS_DATA_W-1:0] i_rd_elem,
    input  wire logic [SW-1:0]                         i_rd_link,
    output logic                                       o_elem_we,
    output logic [SW-1:0]                              o_elem_waddr,
    output logic signed [ols_pkg::OLS_DATA_W-1:0]      o_elem_wdata,
    output logic                                       o_link_we,
    output logic [SW-1:0]                              o_link_waddr,
    output logic [SW-1:0]                              o_link_wdata
);

    ols_pkg::t_ols_state r_state, n_state;
    ols_pkg::t_ols_in    r_req, n_req;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [SW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [SW-1:0]       r_cur, n_cur;
    logic [SW-1:0]       r_prev, n_prev;
    logic [SW-1:0]       r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    ols_pkg::t_ols_out   r_out, n_out;

    logic [SW-1:0]       free_slot;
    logic                out_free;
    logic                full;
    logic                at_last;
    logic                match;
    logic                emit;
    ols_pkg::t_ols_status emit_status;
    logic signed [ols_pkg::OLS_DATA_W-1:0] emit_item;
    logic                emit_last;
    logic [CW+ols_pkg::OLS_LEN_W-1:0] len_ext;

    // lowest numbered free slot
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign full     = (r_count == CW'(CAPACITY));
    assign at_last  = (CW'(r_idx) == (r_count - CW'(1)));
    assign match    = (i_rd_elem == r_req.value);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_used      = r_used;
        n_head      = r_head;
        n_count     = r_count;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        o_in_ready   = 1'b0;
        o_rd_addr    = r_cur;
        o_elem_we    = 1'b0;
        o_elem_waddr = free_slot;
        o_elem_wdata = r_req.value;
        o_link_we    = 1'b0;
        o_link_waddr = free_slot;
        o_link_wdata = r_head;

        emit        = 1'b0;
        emit_status = ols_pkg::ST_OK;
        emit_item   = '0;
        emit_last   = 1'b1;

        case (r_state)
            ols_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_rd_addr  = r_head;
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = ols_pkg::S_START;
                end
            end
            ols_pkg::S_START: begin
                // head read issued here, data is ready in the walk state
                o_rd_addr = r_head;
                n_cur     = r_head;
                n_prev    = r_head;
                n_idx     = '0;
                case (r_req.action)
                    ols_pkg::ACT_INSERT, ols_pkg::ACT_APPEND: begin
                        if (full) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = ols_pkg::ST_FULL;
                                n_state     = ols_pkg::S_IDLE;
                            end
                        end else if (r_req.action == ols_pkg::ACT_INSERT || r_count == '0) begin
                            if (out_free) begin
                                o_elem_we          = 1'b1;
                                o_link_we          = 1'b1;
                                n_head             = free_slot;
                                n_used[free_slot]  = 1'b1;
                                n_count            = r_count + CW'(1);
                                emit               = 1'b1;
                                n_state            = ols_pkg::S_IDLE;
                            end
                        end else begin
                            n_state = ols_pkg::S_WALK;
                        end
                    end
                    ols_pkg::ACT_DELETE: begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = ols_pkg::ST_NOTFOUND;
                                n_state     = ols_pkg::S_IDLE;
                            end
                        end else begin
                            n_state = ols_pkg::S_WALK;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = ols_pkg::ST_EMPTY;
                                n_state     = ols_pkg::S_IDLE;
                            end
                        end else begin
                            n_state = ols_pkg::S_WALK;
                        end
                    end
                endcase
            end
            ols_pkg::S_WALK: begin
                case (r_req.action)
                    ols_pkg::ACT_APPEND: begin
                        if (at_last) begin
                            // hook the new slot behind the tail
                            o_link_we    = 1'b1;
                            o_link_waddr = r_cur;
                            o_link_wdata = free_slot;
                            n_state      = ols_pkg::S_TAIL;
                        end else begin
                            o_rd_addr = i_rd_link;
                            n_prev    = r_cur;
                            n_cur     = i_rd_link;
                            n_idx     = r_idx + SW'(1);
                        end
                    end
                    ols_pkg::ACT_DELETE: begin
                        if (match) begin
                            if (out_free) begin
                                if (r_idx == '0) begin
                                    n_head = i_rd_link;
                                end else begin
                                    o_link_we    = 1'b1;
                                    o_link_waddr = r_prev;
                                    o_link_wdata = i_rd_link;
                                end
                                n_used[r_cur] = 1'b0;
                                n_count       = r_count - CW'(1);
                                emit          = 1'b1;
                                n_state       = ols_pkg::S_IDLE;
                            end
                        end else if (at_last) begin
                            if (out_free) begin
                                emit        = 1'b1;
                                emit_status = ols_pkg::ST_NOTFOUND;
                                n_state     = ols_pkg::S_IDLE;
                            end
                        end else begin
                            o_rd_addr = i_rd_link;
                            n_prev    = r_cur;
                            n_cur     = i_rd_link;
                            n_idx     = r_idx + SW'(1);
                        end
                    end
                    ols_pkg::ACT_DUMP: begin
                        // stalled receiver: keep re-reading the current slot
                        if (out_free) begin
                            emit      = 1'b1;
                            emit_item = i_rd_elem;
                            emit_last = at_last;
                            if (at_last) begin
                                n_state = ols_pkg::S_IDLE;
                            end else begin
                                o_rd_addr = i_rd_link;
                                n_prev    = r_cur;
                                n_cur     = i_rd_link;
                                n_idx     = r_idx + SW'(1);
                            end
                        end
                    end
                    default: begin
                        n_state = ols_pkg::S_IDLE;
                    end
                endcase
            end
            ols_pkg::S_TAIL: begin
                if (out_free) begin
                    o_elem_we         = 1'b1;
                    o_link_we         = 1'b1;
                    o_link_wdata      = '0;
                    n_used[free_slot] = 1'b1;
                    n_count           = r_count + CW'(1);
                    emit              = 1'b1;
                    n_state           = ols_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ols_pkg::S_IDLE;
            end
        endcase

        len_ext = {{ols_pkg::OLS_LEN_W{1'b0}}, n_count};
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out.status = emit_status;
            n_out.item   = emit_item;
            n_out.last   = emit_last;
            n_out.length = len_ext[ols_pkg::OLS_LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ols_pkg::S_IDLE;
            r_used      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `OLS_ASSERT(a_count_bound, r_count <= CAPACITY, "element count above capacity")
    `OLS_ASSERT(a_map_matches_count, $countones(r_used) == r_count, "free map and count disagree")
    `OLS_ASSERT(a_accept_starts, (r_state == ols_pkg::S_IDLE && i_in_valid) |=> (r_state == ols_pkg::S_START), "accepted request did not start")
    `OLS_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_count == '0 && r_used == '0 && !r_out_valid), "reset left list state")

endmodule

`default_nettype wire

// File: bench/tb_ordered_list_store_top.sv
// Self-checking testbench of the ordered list store top level.
`default_nettype none

module tb_ordered_list_store_top;

    import ols_pkg::*;

    localparam int CYCLE_LIMIT     = 500_000;
    localparam int RANDOM_REQUESTS = 250;
    localparam int QUIET_FROM      = 210;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct {
        t_ols_action                  action;
        logic signed [OLS_DATA_W-1:0] value;
        bit                           typed;
        t_ols_status                  status;
        logic [OLS_LEN_W-1:0]         length;
    } t_directed_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_ols_in  i_in;
    logic     o_out_valid;
    logic     i_out_ready;
    t_ols_out o_out;

    // Predicted list contents, front first, and results still to come.
    logic signed [OLS_DATA_W-1:0] held_values[$];
    t_ols_out                     awaited_results[$];
    t_ols_out                     want_result;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int ready_hold     = 0;
    bit quiet          = 1'b0;

    // Typed rows give status and length; item is zero and last is set.
    t_directed_row directed_rows [25] = '{
        '{ACT_DUMP,   32'sd0,            1'b1, ST_EMPTY,    5'd0},
        '{ACT_DELETE, 32'sd5,            1'b1, ST_NOTFOUND, 5'd0},
        '{ACT_APPEND, 32'sh8000_0000,    1'b1, ST_OK,       5'd1},
        '{ACT_INSERT, 32'sh7FFF_FFFF,    1'b1, ST_OK,       5'd2},
        '{ACT_APPEND, 32'sd0,            1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, -32'sd1,           1'b0, ST_OK,       5'd0},
        '{ACT_APPEND, 32'sd3,            1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'sd3,            1'b0, ST_OK,       5'd0},
        '{ACT_APPEND, 32'sh5555_5555,    1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'shAAAA_AAAA,    1'b0, ST_OK,       5'd0},
        '{ACT_APPEND, 32'sd1,            1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'sd3,            1'b0, ST_OK,       5'd0},
        '{ACT_APPEND, -32'sd2,           1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'sh0000_FFFF,    1'b0, ST_OK,       5'd0},
        '{ACT_APPEND, 32'shFFFF_0000,    1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'sd3,            1'b0, ST_OK,       5'd0},
        '{ACT_APPEND, 32'sh7FFF_FFFF,    1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'sh8000_0000,    1'b0, ST_OK,       5'd0},
        '{ACT_INSERT, 32'sd9,            1'b1, ST_FULL,     5'd16},
        '{ACT_APPEND, 32'sd9,            1'b1, ST_FULL,     5'd16},
        '{ACT_DUMP,   32'sd0,            1'b0, ST_OK,       5'd0},
        '{ACT_DELETE, 32'sd3,            1'b0, ST_OK,       5'd0},
        '{ACT_DELETE, 32'sh1234_5678,    1'b1, ST_NOTFOUND, 5'd15},
        '{ACT_DELETE, 32'sh8000_0000,    1'b0, ST_OK,       5'd0},
        '{ACT_DUMP,   32'sd0,            1'b0, ST_OK,       5'd0}
    };

    always #10 i_clk = ~i_clk;

    ordered_list_store_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    function automatic t_ols_out list_result(t_ols_status st, logic signed [OLS_DATA_W-1:0] item,
                                             logic last);
        t_ols_out r;
        r.status = st;
        r.item   = item;
        r.last   = last;
        r.length = OLS_LEN_W'(held_values.size());
        return r;
    endfunction

    // Applies one request to the predicted list and returns its results.
    function automatic void predict_list_request(input t_ols_in req, output t_ols_out res[$]);
        int hit;
        res = {};
        hit = -1;
        case (req.action)
            ACT_INSERT, ACT_APPEND: begin
                if (held_values.size() >= OLS_CAPACITY) begin
                    res.push_back(list_result(ST_FULL, '0, 1'b1));
                end else begin
                    if (req.action == ACT_INSERT) held_values.push_front(req.value);
                    else held_values.push_back(req.value);
                    res.push_back(list_result(ST_OK, '0, 1'b1));
                end
            end
            ACT_DELETE: begin
                foreach (held_values[i])
                    if (hit < 0 && held_values[i] == req.value) hit = i;
                if (hit >= 0) begin
                    held_values.delete(hit);
                    res.push_back(list_result(ST_OK, '0, 1'b1));
                end else begin
                    res.push_back(list_result(ST_NOTFOUND, '0, 1'b1));
                end
            end
            default: begin
                if (held_values.size() == 0)
                    res.push_back(list_result(ST_EMPTY, '0, 1'b1));
                else
                    foreach (held_values[i])
                        res.push_back(list_result(ST_OK, held_values[i],
                                                  i == held_values.size() - 1));
            end
        endcase
    endfunction

    function automatic logic signed [OLS_DATA_W-1:0] pick_value();
        logic signed [OLS_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2, 3, 4: v = $signed(32'($urandom_range(0, 8))) - 32'sd4; // dense, for duplicates
            5:       v = $urandom_range(0, 1) ? '1 : '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Alternates growing and shrinking stretches so the list hits full and empty.
    function automatic t_ols_in pick_random_request(int n);
        t_ols_in req;
        int      roll;
        bit      grow;
        grow = ((n / 50) % 2) == 0;
        roll = $urandom_range(0, 99);
        if (grow)
            req.action = roll < 35 ? ACT_INSERT : roll < 70 ? ACT_APPEND :
                         roll < 85 ? ACT_DELETE : ACT_DUMP;
        else
            req.action = roll < 10 ? ACT_INSERT : roll < 20 ? ACT_APPEND :
                         roll < 85 ? ACT_DELETE : ACT_DUMP;
        req.value = pick_value();
        if (req.action == ACT_DELETE && held_values.size() != 0 && $urandom_range(0, 9) < 7)
            req.value = held_values[$urandom_range(0, held_values.size() - 1)];
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_ols_in req, input bit typed, input t_ols_out typed_res);
        t_ols_out res[$];
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_list_request(req, res);
        if (typed) awaited_results.push_back(typed_res);
        else foreach (res[k]) awaited_results.push_back(res[k]);
        @(negedge i_clk);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    // Receiver stalls in bursts of random length.
    always @(negedge i_clk) begin
        if (quiet) begin
            ready_hold  = 0;
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold  = ready_hold - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold  = $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d item %0d", o_out.status, o_out.item);
                mismatch_count++;
            end else begin
                want_result = awaited_results.pop_front();
                if (o_out.status !== want_result.status) begin
                    $error("status: expected %0d, got %0d", want_result.status, o_out.status);
                    mismatch_count++;
                end
                if (o_out.item !== want_result.item) begin
                    $error("item: expected %0d, got %0d", want_result.item, o_out.item);
                    mismatch_count++;
                end
                if (o_out.last !== want_result.last) begin
                    $error("last: expected %0d, got %0d", want_result.last, o_out.last);
                    mismatch_count++;
                end
                if (o_out.length !== want_result.length) begin
                    $error("length: expected %0d, got %0d", want_result.length, o_out.length);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_ordered_list_store_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_ols_in  req;
        t_ols_out typed_res;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            maybe_gap();
            req.action       = directed_rows[r].action;
            req.value        = directed_rows[r].value;
            typed_res.status = directed_rows[r].status;
            typed_res.item   = '0;
            typed_res.last   = 1'b1;
            typed_res.length = directed_rows[r].length;
            send_request(req, directed_rows[r].typed, typed_res);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            quiet = (n >= 60 && n < 100) || n >= QUIET_FROM;
            if (n == RANDOM_REQUESTS / 2) begin
                // hold off new requests until the block has drained
                i_in_valid <= 1'b0;
                while (awaited_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            maybe_gap();
            send_request(pick_random_request(n), 1'b0, typed_res);
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_ordered_list_store_top: done, clean");
        else
            $display("tb_ordered_list_store_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
